/* src/lzrd_pkg.sv */
package lzrd_pkg;

	localparam int RingSize = 4096;
	localparam int RingAw = $clog2(RingSize);
	localparam int FillW = RingAw + 1;
	localparam int MaxMatch = 18;
	localparam int CntW = $clog2(MaxMatch);

	// first write position after a restart
	localparam logic [RingAw-1:0] RING_BASE = RingAw'(RingSize - MaxMatch);
	localparam logic [FillW-1:0] FILL_FULL = FillW'(RingSize);
	localparam logic [7:0] SPACE = 8'h20;
	// remaining-count load: length - 1 = low nibble + bias
	localparam logic [CntW-1:0] MATCH_BIAS = CntW'(2);
	localparam logic [3:0] FLAG_COUNT = 4'd8;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_ITEM,
		PH_MATCH2
	} phase_t;

	// read/forward stage in front of the output register
	typedef struct packed {
		logic       valid;
		logic       last;
		logic       fwd;
		logic       hit;
		logic [7:0] data;
	} s1_t;

endpackage

/* src/lzrd_if.sv */
interface lzrd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_stream;

	modport source (output valid, output in_byte, output start_of_stream, input ready);
	modport sink (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface lzrd_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* src/lzrd_ring.sv */
module lzrd_ring (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [lzrd_pkg::RingAw-1:0] wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [lzrd_pkg::RingAw-1:0] rd_addr,
	output logic [7:0]                 rd_data
);
	import lzrd_pkg::*;

	logic [7:0] mem [RingSize];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data while the pipeline is stalled
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* src/lzss_ring_decoder_unit.sv */
// LZSS decoder with a 4096-byte history ring (matches of 3 to 18 bytes). One compressed byte
// is taken per request on code; decoded bytes leave on text, last_of_run marking the final
// byte produced by a request. Flag bytes and first match bytes give no output. The second
// match byte starts a copy of 3 to 18 bytes, one per cycle unless the output stalls, through
// the single read port of the ring memory, and code stays not ready until the last read of
// the copy has been issued. Output back-pressure stalls the whole pipeline. The ring is never
// swept: a fill count since the last restart marks which entries were written, and unwritten
// entries read as spaces, so start_of_stream and reset take effect at once.
module lzss_ring_decoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	lzrd_code_if.sink    code,
	lzrd_text_if.source  text
);
	import lzrd_pkg::*;

	phase_t              phase_q, phase_d, eff_phase;
	logic [7:0]          flag_bits_q, flag_bits_d, eff_bits;
	logic [3:0]          flags_left_q, flags_left_d, eff_left, left_dec;
	logic [7:0]          ofs_q;

	logic [RingAw-1:0]   wp_q;
	logic [FillW-1:0]    fill_q;

	logic                copy_busy_q;
	logic [RingAw-1:0]   src_q;
	logic [CntW-1:0]     cnt_q;

	s1_t                 s1_q, s1_d;
	logic [7:0]          s1_byte;
	logic [7:0]          rd_data;

	logic                text_valid_q;
	logic [7:0]          text_byte_q;
	logic                text_last_q;

	logic                advance, acc, issue, wr_en, hit, fwd_now;
	logic                is_literal, is_match1, is_match2;
	logic [RingAw-1:0]   rel;

	assign advance    = !text_valid_q || text.ready;
	assign code.ready = !copy_busy_q && advance;
	assign acc        = code.valid && code.ready;

	// a restart applies before the byte that carries it
	assign eff_phase = code.start_of_stream ? PH_FLAG : phase_q;
	assign eff_bits  = code.start_of_stream ? 8'd0 : flag_bits_q;
	assign eff_left  = code.start_of_stream ? 4'd0 : flags_left_q;
	assign left_dec  = (eff_left != 4'd0) ? eff_left - 4'd1 : 4'd0;

	always_comb begin
		phase_d      = phase_q;
		flag_bits_d  = flag_bits_q;
		flags_left_d = flags_left_q;
		if (acc) begin
			case (eff_phase)
				PH_ITEM: begin
					if (eff_bits[0]) begin
						flag_bits_d  = eff_bits >> 1;
						flags_left_d = left_dec;
						phase_d      = (left_dec == 4'd0) ? PH_FLAG : PH_ITEM;
					end else begin
						phase_d = PH_MATCH2;
					end
				end
				PH_MATCH2: begin
					flag_bits_d  = eff_bits >> 1;
					flags_left_d = left_dec;
					phase_d      = (left_dec == 4'd0) ? PH_FLAG : PH_ITEM;
				end
				default: begin
					flag_bits_d  = code.in_byte;
					flags_left_d = FLAG_COUNT;
					phase_d      = PH_ITEM;
				end
			endcase
		end
	end

	always_comb begin
		is_literal = 1'b0;
		is_match1  = 1'b0;
		is_match2  = 1'b0;
		case (eff_phase)
			PH_ITEM: begin
				is_literal = acc && eff_bits[0];
				is_match1  = acc && !eff_bits[0];
			end
			PH_MATCH2: begin
				is_match2 = acc;
			end
			default: begin
			end
		endcase
	end

	// entry written since restart if it lies within fill_q of the start position
	assign rel     = src_q - RING_BASE;
	assign hit     = {1'b0, rel} < fill_q;
	assign fwd_now = s1_q.valid && (src_q == wp_q);
	assign issue   = copy_busy_q && advance;
	assign wr_en   = s1_q.valid && advance;

	assign s1_byte = s1_q.fwd ? s1_q.data : (s1_q.hit ? rd_data : SPACE);

	always_comb begin
		s1_d = '0;
		if (issue) begin
			s1_d.valid = 1'b1;
			s1_d.last  = (cnt_q == '0);
			s1_d.fwd   = fwd_now;
			s1_d.hit   = hit;
			s1_d.data  = s1_byte;
		end else if (is_literal) begin
			s1_d.valid = 1'b1;
			s1_d.last  = 1'b1;
			s1_d.fwd   = 1'b1;
			s1_d.hit   = 1'b0;
			s1_d.data  = code.in_byte;
		end
	end

	lzrd_ring u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (s1_byte),
		.rd_en   (issue),
		.rd_addr (src_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FLAG;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
		end else begin
			phase_q      <= phase_d;
			flag_bits_q  <= flag_bits_d;
			flags_left_q <= flags_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (is_match1) begin
			ofs_q <= code.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= RING_BASE;
			fill_q <= '0;
		end else if (acc && code.start_of_stream) begin
			// an in-flight write of the old stream falls outside the new fill range
			wp_q   <= RING_BASE;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= wp_q + 1'b1;
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_busy_q <= 1'b0;
			src_q       <= '0;
			cnt_q       <= '0;
		end else if (is_match2) begin
			copy_busy_q <= 1'b1;
			src_q       <= {code.in_byte[7:4], ofs_q};
			cnt_q       <= {{(CntW-4){1'b0}}, code.in_byte[3:0]} + MATCH_BIAS;
		end else if (issue) begin
			src_q <= src_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				copy_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (advance) begin
			s1_q <= s1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
		end else if (advance) begin
			text_valid_q <= s1_q.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_byte_q <= s1_byte;
			text_last_q <= s1_q.last;
		end
	end

	assign text.valid       = text_valid_q;
	assign text.out_byte    = text_byte_q;
	assign text.last_of_run = text_last_q;

endmodule
